// ===== rtl/rec_env_pkg.sv =====
// ----------------------------------------------------------------------------
// Record envelope checker package
// Shared types, header layout constants and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package rec_env_pkg;

  // Default largest record the byte counter tracks before it saturates.
  localparam int unsigned REC_MAX_RECORD_BYTES = 65536;
  // Fixed header length in bytes.
  localparam int unsigned REC_HEADER_BYTES = 24;

  // Header field offsets.
  localparam int unsigned OFF_SCHEMA   = 4;
  localparam int unsigned OFF_KIND     = 6;
  localparam int unsigned OFF_RSV_BYTE = 7;
  localparam int unsigned OFF_GEN      = 8;
  localparam int unsigned OFF_LEN      = 12;
  localparam int unsigned OFF_CRC      = 16;
  localparam int unsigned OFF_RSV_WORD = 20;

  // CRC-32 (reflected) polynomial, initial value and final inversion.
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ONES = 32'hffffffff;

  // Reset value of the size limit register.
  localparam logic [16:0] MAX_SIZE_RESET = 17'h10000;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CONFIG  = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_CORRUPT     = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } rec_status_e;

  typedef enum logic [1:0] {
    CFG_MAGIC  = 2'd0,
    CFG_SCHEMA = 2'd1,
    CFG_KIND   = 2'd2,
    CFG_MAX    = 2'd3
  } rec_cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rec_env_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] generation_out;
    logic [31:0] crc_out;
    logic [15:0] payload_bytes;
  } rec_env_out_t;

  // Record summary after the byte being processed, handed to the verdict logic.
  typedef struct packed {
    logic        hdr_ok;
    logic        rsv_ok;
    logic [15:0] schema;
    logic [31:0] generation;
    logic [31:0] length;
    logic [31:0] stored_crc;
    logic [31:0] calc_crc;
  } rec_env_snap_t;

  // One byte through the reflected CRC-32, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/rec_env_tracker.sv =====
// ----------------------------------------------------------------------------
// Record envelope tracker
// Holds the per-record state: byte counter, running CRC and header fields.
// ----------------------------------------------------------------------------
module rec_env_tracker
  import rec_env_pkg::*;
#(
  parameter int unsigned MaxRecordBytes = REC_MAX_RECORD_BYTES,
  localparam int unsigned CW = $clog2(MaxRecordBytes + 2)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic [31:0]   magic_i,
  input  logic [7:0]    kind_i,
  output logic [CW-1:0] byte_count_o,
  output logic [CW-1:0] count_o,
  output rec_env_snap_t snap_o
);

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   crc_q, crc_d;
  logic          hdr_ok_q, hdr_ok_d;
  logic          rsv_ok_q, rsv_ok_d;
  logic [15:0]   schema_q, schema_d;
  logic [31:0]   gen_q, gen_d;
  logic [31:0]   len_q, len_d;
  logic [31:0]   stored_q, stored_d;
  logic [1:0]    lane;
  logic [7:0]    crc_in;

  assign lane = count_q[1:0];

  always_comb begin
    hdr_ok_d = hdr_ok_q;
    rsv_ok_d = rsv_ok_q;
    schema_d = schema_q;
    gen_d    = gen_q;
    len_d    = len_q;
    stored_d = stored_q;

    priority if (count_q < CW'(OFF_SCHEMA)) begin
      if (magic_i[{lane, 3'b000} +: 8] != byte_i) hdr_ok_d = 1'b0;
    end else if (count_q < CW'(OFF_KIND)) begin
      schema_d[{lane[0], 3'b000} +: 8] = byte_i;
    end else if (count_q == CW'(OFF_KIND)) begin
      if (byte_i != kind_i) hdr_ok_d = 1'b0;
    end else if (count_q == CW'(OFF_RSV_BYTE)) begin
      if (byte_i != 8'd0) rsv_ok_d = 1'b0;
    end else if (count_q < CW'(OFF_LEN)) begin
      gen_d[{lane, 3'b000} +: 8] = byte_i;
    end else if (count_q < CW'(OFF_CRC)) begin
      len_d[{lane, 3'b000} +: 8] = byte_i;
    end else if (count_q < CW'(OFF_RSV_WORD)) begin
      stored_d[{lane, 3'b000} +: 8] = byte_i;
    end else if (count_q < CW'(REC_HEADER_BYTES)) begin
      if (byte_i != 8'd0) rsv_ok_d = 1'b0;
    end else begin
      // Payload byte: only the CRC and the counter move.
    end

    // The stored CRC field enters the checksum as zero bytes.
    crc_in = (count_q >= CW'(OFF_CRC) && count_q < CW'(OFF_RSV_WORD)) ? 8'd0 : byte_i;
    crc_d  = crc_byte(crc_q, crc_in);

    count_d = (count_q <= CW'(MaxRecordBytes)) ? count_q + CW'(1) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      crc_q    <= CRC_ONES;
      hdr_ok_q <= 1'b1;
      rsv_ok_q <= 1'b1;
      schema_q <= '0;
      gen_q    <= '0;
      len_q    <= '0;
      stored_q <= '0;
    end else if (adv_i) begin
      if (last_i) begin
        count_q  <= '0;
        crc_q    <= CRC_ONES;
        hdr_ok_q <= 1'b1;
        rsv_ok_q <= 1'b1;
        schema_q <= '0;
        gen_q    <= '0;
        len_q    <= '0;
        stored_q <= '0;
      end else begin
        count_q  <= count_d;
        crc_q    <= crc_d;
        hdr_ok_q <= hdr_ok_d;
        rsv_ok_q <= rsv_ok_d;
        schema_q <= schema_d;
        gen_q    <= gen_d;
        len_q    <= len_d;
        stored_q <= stored_d;
      end
    end
  end

  assign byte_count_o = count_q;
  assign count_o      = count_d;

  always_comb begin
    snap_o.hdr_ok     = hdr_ok_d;
    snap_o.rsv_ok     = rsv_ok_d;
    snap_o.schema     = schema_d;
    snap_o.generation = gen_d;
    snap_o.length     = len_d;
    snap_o.stored_crc = stored_d;
    snap_o.calc_crc   = crc_d ^ CRC_ONES;
  end

endmodule

// ===== rtl/rec_env_judge.sv =====
// ----------------------------------------------------------------------------
// Record envelope verdict
// Turns the finished record summary into a status and the reported fields.
// ----------------------------------------------------------------------------
module rec_env_judge
  import rec_env_pkg::*;
#(
  parameter int unsigned MaxRecordBytes = REC_MAX_RECORD_BYTES,
  localparam int unsigned CW = $clog2(MaxRecordBytes + 2),
  localparam int unsigned WW = (CW > 17) ? CW : 17
) (
  input  logic [CW-1:0] count_i,
  input  rec_env_snap_t snap_i,
  input  logic [15:0]   exp_schema_i,
  input  logic [16:0]   max_size_i,
  output rec_env_out_t  result_o
);

  rec_status_e status;
  logic [31:0] body_len;
  logic        bad_cfg, too_large, corrupt_a, corrupt_b;

  // Payload length from the byte count; only meaningful past the header.
  assign body_len = 32'(count_i) - 32'(REC_HEADER_BYTES);

  assign bad_cfg   = (exp_schema_i == 16'd0) || (max_size_i < 17'(REC_HEADER_BYTES));
  assign too_large = (WW'(count_i) > WW'(max_size_i)) || (count_i > CW'(MaxRecordBytes));
  assign corrupt_a = (count_i < CW'(REC_HEADER_BYTES)) || !snap_i.hdr_ok ||
                     (snap_i.length != body_len) || (snap_i.stored_crc != snap_i.calc_crc);
  assign corrupt_b = !snap_i.rsv_ok || (snap_i.generation == 32'd0);

  always_comb begin
    priority if (bad_cfg)                        status = ST_BAD_CONFIG;
    else if (too_large)                          status = ST_TOO_LARGE;
    else if (corrupt_a)                          status = ST_CORRUPT;
    else if (snap_i.schema != exp_schema_i)      status = ST_UNSUPPORTED;
    else if (corrupt_b)                          status = ST_CORRUPT;
    else                                         status = ST_OK;

    result_o.status = status;
    if (status == ST_OK) begin
      result_o.generation_out = snap_i.generation;
      result_o.crc_out        = snap_i.stored_crc;
      result_o.payload_bytes  = body_len[15:0];
    end else begin
      result_o.generation_out = '0;
      result_o.crc_out        = '0;
      result_o.payload_bytes  = '0;
    end
  end

endmodule

// ===== rtl/record_envelope_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Record envelope checker
// Validates the 24-byte header and CRC-32 of a record streamed byte by byte.
// ----------------------------------------------------------------------------
// The checker takes one record byte per cycle while its input side does not
// stall, and gives one status request for every byte flagged as last. A byte
// first lands in an input register; from there the byte-wide CRC step and
// the header capture update the record state, and for a last byte the
// verdict is loaded into the result register. The input side stalls only
// while a last byte waits behind a result that the sink has not yet taken;
// non-final bytes keep flowing even then, because they produce no result.
// The per-record state returns to its reset values as soon as the last byte
// has been judged, so the next record may follow in the very next cycle.
// Configuration is written through a plain write port and must only change
// while no record is in flight. Records longer than MaxRecordBytes are
// reported as too large unless the configuration is invalid; the byte
// counter saturates one past that limit.
// ----------------------------------------------------------------------------
module record_envelope_checker_unit
  import rec_env_pkg::*;
#(
  parameter int unsigned MaxRecordBytes = REC_MAX_RECORD_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  rec_env_in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output rec_env_out_t out_data_o
);

  localparam int unsigned CW = $clog2(MaxRecordBytes + 2);

  // Configuration registers.
  logic [31:0] magic_q;
  logic [15:0] schema_q;
  logic [7:0]  kind_q;
  logic [16:0] max_size_q;

  rec_cfg_idx_e cfg_idx;
  assign cfg_idx = rec_cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= '0;
      schema_q   <= '0;
      kind_q     <= '0;
      max_size_q <= MAX_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_MAGIC:  magic_q    <= cfg_wdata_i;
        CFG_SCHEMA: schema_q   <= cfg_wdata_i[15:0];
        CFG_KIND:   kind_q     <= cfg_wdata_i[7:0];
        CFG_MAX:    max_size_q <= cfg_wdata_i[16:0];
        default:    ;
      endcase
    end
  end

  // Input register: one byte waiting to be folded into the record state.
  logic        s1_valid_q;
  rec_env_in_t s1_data_q;
  logic        s1_adv;
  logic        load_result;
  logic        in_take;

  // A byte moves on unless it would need the result register while it is full
  // and the sink is holding it.
  assign s1_adv      = s1_valid_q &&
                       (!s1_data_q.last_byte || !out_valid_o || !out_stall_i);
  assign load_result = s1_adv && s1_data_q.last_byte;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_take     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
  end

  // Record state and verdict.
  logic [CW-1:0] byte_count;
  logic [CW-1:0] count_next;
  rec_env_snap_t snap;
  rec_env_out_t  result;

  rec_env_tracker #(
    .MaxRecordBytes(MaxRecordBytes)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .byte_i      (s1_data_q.data_byte),
    .last_i      (s1_data_q.last_byte),
    .magic_i     (magic_q),
    .kind_i      (kind_q),
    .byte_count_o(byte_count),
    .count_o     (count_next),
    .snap_o      (snap)
  );

  rec_env_judge #(
    .MaxRecordBytes(MaxRecordBytes)
  ) u_judge (
    .count_i     (count_next),
    .snap_i      (snap),
    .exp_schema_i(schema_q),
    .max_size_i  (max_size_q),
    .result_o    (result)
  );

  // Result register.
  logic         out_valid_q;
  rec_env_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The input side only ever waits on a final byte blocked by an untaken result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_data_q.last_byte && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked final byte");

  // Once a final byte has been judged, the next record starts at offset zero.
  a_record_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (byte_count == '0))
    else $error("record state not cleared after final byte");

  // A good record never carries a zero generation.
  a_ok_generation : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OK) |-> (out_data_o.generation_out != 32'd0))
    else $error("good record reported with zero generation");

  // Any failing status reports zero fields.
  a_fail_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (out_data_o.generation_out == 32'd0 && out_data_o.crc_out == 32'd0 &&
       out_data_o.payload_bytes == 16'd0))
    else $error("failing record reported with nonzero fields");

endmodule

// ===== test/rec_env_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record verdict checker
// Follows register writes and the record byte stream, predicts the status of
// every record and compares it field by field with the verdicts returned.
// ----------------------------------------------------------------------------
module rec_env_verdict_checker
  import rec_env_pkg::*;
#(
  parameter int unsigned MaxRecordBytes = REC_MAX_RECORD_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         in_valid_i,
  input  logic         in_stall_i,
  input  rec_env_in_t  in_data_i,
  input  logic         out_valid_i,
  input  logic         out_stall_i,
  input  rec_env_out_t out_data_i,
  output int           mismatch_count_o,
  output int           pending_o,
  output int           verdict_count_o
);

  // Register copies.
  logic [31:0] reg_magic;
  logic [15:0] reg_schema;
  logic [7:0]  reg_kind;
  logic [16:0] reg_max;

  // Per-record state.
  int unsigned rec_len;
  logic [31:0] crc_acc;
  logic        hdr_good;
  logic        rsv_good;
  logic [15:0] schema_cap;
  logic [31:0] gen_cap;
  logic [31:0] len_cap;
  logic [31:0] crc_cap;

  rec_env_out_t expected_verdicts[$];
  int           mismatches;
  int           verdicts;

  // Reflected CRC-32, one data bit at a time.
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] octet);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ octet[i]) begin
        r = {1'b0, r[31:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[31:1]};
      end
    end
    return r;
  endfunction

  task automatic clear_record();
    rec_len    = 0;
    crc_acc    = CRC_ONES;
    hdr_good   = 1'b1;
    rsv_good   = 1'b1;
    schema_cap = '0;
    gen_cap    = '0;
    len_cap    = '0;
    crc_cap    = '0;
  endtask

  task automatic absorb_byte(input rec_env_in_t req);
    int unsigned  off;
    int unsigned  sh;
    logic [7:0]   fed;
    logic [31:0]  crc_final;
    logic [31:0]  want_len;
    rec_env_out_t v;
    off = rec_len;
    sh  = 8 * (off % 4);
    fed = req.data_byte;
    if (off < OFF_SCHEMA) begin
      if (reg_magic[sh +: 8] != req.data_byte) hdr_good = 1'b0;
    end else if (off < OFF_KIND) begin
      schema_cap[8 * (off % 2) +: 8] = req.data_byte;
    end else if (off == OFF_KIND) begin
      if (req.data_byte != reg_kind) hdr_good = 1'b0;
    end else if (off == OFF_RSV_BYTE) begin
      if (req.data_byte != 8'd0) rsv_good = 1'b0;
    end else if (off < OFF_LEN) begin
      gen_cap[sh +: 8] = req.data_byte;
    end else if (off < OFF_CRC) begin
      len_cap[sh +: 8] = req.data_byte;
    end else if (off < OFF_RSV_WORD) begin
      crc_cap[sh +: 8] = req.data_byte;
      fed = 8'd0;
    end else if (off < REC_HEADER_BYTES) begin
      if (req.data_byte != 8'd0) rsv_good = 1'b0;
    end
    crc_acc = crc32_step(crc_acc, fed);
    if (rec_len <= MaxRecordBytes) rec_len++;

    if (req.last_byte) begin
      crc_final = crc_acc ^ CRC_ONES;
      want_len  = rec_len - REC_HEADER_BYTES;
      v = '0;
      if (reg_schema == '0 || reg_max < REC_HEADER_BYTES) begin
        v.status = ST_BAD_CONFIG;
      end else if (rec_len > reg_max || rec_len > MaxRecordBytes) begin
        v.status = ST_TOO_LARGE;
      end else if (rec_len < REC_HEADER_BYTES || !hdr_good || len_cap != want_len ||
                   crc_cap != crc_final) begin
        v.status = ST_CORRUPT;
      end else if (schema_cap != reg_schema) begin
        v.status = ST_UNSUPPORTED;
      end else if (!rsv_good || gen_cap == '0) begin
        v.status = ST_CORRUPT;
      end else begin
        v.status         = ST_OK;
        v.generation_out = gen_cap;
        v.crc_out        = crc_cap;
        v.payload_bytes  = want_len[15:0];
      end
      expected_verdicts.push_back(v);
      clear_record();
    end
  endtask

  task automatic check_verdict(input rec_env_out_t got);
    rec_env_out_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected verdict with status %0d: no record was waiting", got.status);
      mismatches++;
    end else begin
      want = expected_verdicts.pop_front();
      verdicts++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.generation_out !== want.generation_out) begin
        $error("generation_out: expected %h, actual %h", want.generation_out,
               got.generation_out);
        mismatches++;
      end
      if (got.crc_out !== want.crc_out) begin
        $error("crc_out: expected %h, actual %h", want.crc_out, got.crc_out);
        mismatches++;
      end
      if (got.payload_bytes !== want.payload_bytes) begin
        $error("payload_bytes: expected %0d, actual %0d", want.payload_bytes,
               got.payload_bytes);
        mismatches++;
      end
    end
  endtask

  // A verdict leaving at an edge always belongs to an earlier record than a
  // byte taken at the same edge, so it is compared first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_magic  = '0;
      reg_schema = '0;
      reg_kind   = '0;
      reg_max    = MAX_SIZE_RESET;
      clear_record();
      expected_verdicts.delete();
      mismatches = 0;
      verdicts   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_verdict(out_data_i);
      if (in_valid_i && !in_stall_i) absorb_byte(in_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAGIC:  reg_magic  = cfg_wdata_i;
          CFG_SCHEMA: reg_schema = cfg_wdata_i[15:0];
          CFG_KIND:   reg_kind   = cfg_wdata_i[7:0];
          CFG_MAX:    reg_max    = cfg_wdata_i[16:0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_verdicts.size();
    verdict_count_o  <= verdicts;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record envelope checker testbench
// Streams well-formed, damaged and noise records through the checker unit
// under a series of register settings, with a bursty sender and a stalling
// sink; a separate checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb;
  import rec_env_pkg::*;

  // Sink behaviour codes.
  localparam int SINK_FREE  = 0;
  localparam int SINK_LIGHT = 1;
  localparam int SINK_HEAVY = 2;

  // Longest quiet stretch of a correct run: a sink stall, a sender gap, the
  // pause before register writes and the wait for a verdict. The limit is far
  // beyond that.
  localparam int QUIET_LIMIT = 2000;

  localparam int RANDOM_PHASES     = 8;
  localparam int RECORDS_PER_PHASE = 3;

  // Which header defects a built record carries; any mix may be set.
  typedef struct packed {
    logic magic;
    logic schema;
    logic kind;
    logic rsv_byte;
    logic gen_zero;
    logic length;
    logic crc;
    logic rsv_word;
  } rec_faults_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  rec_env_in_t  in_data = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  rec_env_out_t out_data;

  int mismatch_total;
  int pending_total;
  int verdict_total;

  // Register values as last written, for building matching records.
  logic [31:0] cur_magic  = '0;
  logic [15:0] cur_schema = '0;
  logic [7:0]  cur_kind   = '0;
  logic [16:0] cur_max    = MAX_SIZE_RESET;

  logic [7:0] rec_bytes[$];

  logic req_taken = 1'b0;
  int   burst_left = 0;
  int   gap_limit = 12;
  int   sink_mode = SINK_LIGHT;
  int   sink_run = 0;
  int   quiet_cycles = 0;
  int   records_sent = 0;
  int   bytes_sent = 0;
  int   settings_used = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  record_envelope_checker_unit #(
    .MaxRecordBytes(REC_MAX_RECORD_BYTES)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rec_env_verdict_checker #(
    .MaxRecordBytes(REC_MAX_RECORD_BYTES)
  ) u_verdict_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_total),
    .pending_o        (pending_total),
    .verdict_count_o  (verdict_total)
  );

  // The acceptance seen at a rising edge is latched here, so the driver can
  // read it safely at the following falling edge.
  always @(posedge clk) begin
    req_taken <= in_valid && !in_stall;
  end

  // The sink holds stall for runs of random length. In the light mode stalls
  // are short and rare, in the heavy mode long and frequent.
  always @(negedge clk) begin
    if (sink_run == 0) begin
      case (sink_mode)
        SINK_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
          sink_run  <= $urandom_range(1, 4);
        end
        SINK_HEAVY: begin
          out_stall <= ($urandom_range(0, 1) == 0);
          sink_run  <= $urandom_range(1, 30);
        end
        default: begin
          out_stall <= 1'b0;
          sink_run  <= 16;
        end
      endcase
    end else begin
      sink_run <= sink_run - 1;
    end
  end

  // Watchdog: any cycle in which neither channel moves a request counts
  // towards the limit; a deadlock therefore ends the run as a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No request moved for %0d cycles.", QUIET_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte and waits until it has been accepted. The sender works
  // in bursts; once a burst is used up it may drop valid for a random gap.
  task automatic send_item(input rec_env_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_limit);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    @(negedge clk);
    while (!req_taken) @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_record();
    rec_env_in_t req;
    for (int i = 0; i < rec_bytes.size(); i++) begin
      req.data_byte = rec_bytes[i];
      req.last_byte = (i == rec_bytes.size() - 1);
      send_item(req);
    end
    records_sent++;
  endtask

  // Lets every verdict come back, then a few idle cycles more, so that the
  // registers may be rewritten with nothing in flight.
  task automatic drain_and_pause();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_total != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes all four registers in consecutive cycles. Bits above a register's
  // width carry junk, which the block has to ignore.
  task automatic program_regs(input logic [31:0] magic, input logic [15:0] schema,
                              input logic [7:0] kind, input logic [16:0] max_size);
    logic [31:0] junk;
    junk      = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= magic;
    @(negedge clk);
    cfg_index <= CFG_SCHEMA;
    cfg_wdata <= {junk[15:0], schema};
    @(negedge clk);
    cfg_index <= CFG_KIND;
    cfg_wdata <= {junk[31:8], kind};
    @(negedge clk);
    cfg_index <= CFG_MAX;
    cfg_wdata <= {junk[14:0], max_size};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_magic  = magic;
    cur_schema = schema;
    cur_kind   = kind;
    cur_max    = max_size;
    settings_used++;
  endtask

  task automatic push_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) rec_bytes.push_back(value[8 * i +: 8]);
  endtask

  // Builds a record against the current registers, with the defects that the
  // fault flags ask for, and seals it with its CRC (taken with the CRC field
  // as zero).
  task automatic build_record(input int unsigned pay_len, input rec_faults_t flt,
                              input logic [31:0] generation);
    logic [31:0] magic_f;
    logic [15:0] schema_f;
    logic [7:0]  kind_f;
    logic [7:0]  rsv_b;
    logic [31:0] gen_f;
    logic [31:0] len_f;
    logic [31:0] rsv_w;
    logic [31:0] crc_v;
    int          fill;
    magic_f  = flt.magic ? cur_magic ^ (32'd1 << $urandom_range(0, 31)) : cur_magic;
    schema_f = flt.schema ? cur_schema ^ 16'($urandom_range(1, 65535)) : cur_schema;
    kind_f   = flt.kind ? cur_kind ^ 8'($urandom_range(1, 255)) : cur_kind;
    rsv_b    = flt.rsv_byte ? 8'($urandom_range(1, 255)) : 8'd0;
    gen_f    = flt.gen_zero ? 32'd0 : ((generation == 32'd0) ? 32'd1 : generation);
    len_f    = flt.length ? pay_len ^ (32'd1 << $urandom_range(0, 31)) : pay_len;
    rsv_w    = flt.rsv_word ? ($urandom | (32'd1 << $urandom_range(0, 31))) : 32'd0;
    rec_bytes.delete();
    push_le(magic_f, 4);
    push_le({16'd0, schema_f}, 2);
    push_le({24'd0, kind_f}, 1);
    push_le({24'd0, rsv_b}, 1);
    push_le(gen_f, 4);
    push_le(len_f, 4);
    push_le(32'd0, 4);
    push_le(rsv_w, 4);
    // Most payloads are random; some are all zeros or all ones.
    fill = $urandom_range(0, 7);
    for (int unsigned i = 0; i < pay_len; i++) begin
      if (fill == 0) rec_bytes.push_back(8'h00);
      else if (fill == 1) rec_bytes.push_back(8'hff);
      else rec_bytes.push_back(8'($urandom));
    end
    crc_v = CRC_ONES;
    foreach (rec_bytes[i]) crc_v = crc_byte(crc_v, rec_bytes[i]);
    crc_v = crc_v ^ CRC_ONES;
    if (flt.crc) crc_v = crc_v ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) rec_bytes[OFF_CRC + i] = crc_v[8 * i +: 8];
  endtask

  task automatic fill_noise(input int nbytes);
    rec_bytes.delete();
    repeat (nbytes) rec_bytes.push_back(8'($urandom));
  endtask

  // Random record: mostly well-formed with random content, the rest damaged
  // headers, oversize records, short fragments and plain noise.
  task automatic send_random_record();
    int unsigned pick;
    int unsigned cap;
    int unsigned len;
    logic [7:0]  flt_bits;
    rec_faults_t flt;
    pick = $urandom_range(0, 99);
    cap  = (cur_max >= REC_HEADER_BYTES) ? cur_max - REC_HEADER_BYTES : 16;
    if (cap > 32) cap = 32;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, cap);
    else len = $urandom_range(0, (cap < 4) ? cap : 4);
    flt = '0;
    if (pick < 65) begin
      build_record(len, flt, $urandom);
    end else if (pick < 85) begin
      flt_bits = '0;
      while (flt_bits == '0) flt_bits = 8'($urandom & $urandom);
      flt = flt_bits;
      build_record(len, flt, $urandom);
    end else if (pick < 90 && cur_max >= REC_HEADER_BYTES && cur_max <= 200) begin
      build_record(cur_max - REC_HEADER_BYTES + $urandom_range(1, 20), flt, $urandom);
    end else if (pick < 95) begin
      fill_noise($urandom_range(1, REC_HEADER_BYTES - 1));
    end else begin
      fill_noise($urandom_range(1, 40));
    end
    send_record();
  endtask

  initial begin
    rec_faults_t flt;
    logic [31:0] magic_sel;
    logic [15:0] schema_sel;
    logic [7:0]  kind_sel;
    logic [16:0] max_sel;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // ---- Directed part ----
    // Registers still hold their reset values; a zero schema register means
    // an invalid configuration.
    build_record(4, '0, $urandom);
    send_record();
    drain_and_pause();

    program_regs($urandom, 16'($urandom_range(1, 65535)), 8'($urandom), MAX_SIZE_RESET);
    // Good records: empty payload with an all-ones generation, then a short one.
    build_record(0, '0, 32'hffff_ffff);
    send_record();
    build_record(7, '0, 32'd1);
    send_record();
    // Every header defect on its own.
    for (int f = 0; f < 8; f++) begin
      build_record(5, rec_faults_t'(8'd1 << f), $urandom);
      send_record();
    end
    // Records shorter than the header: a lone last byte, and one byte short.
    fill_noise(1);
    send_record();
    fill_noise(REC_HEADER_BYTES - 1);
    send_record();
    // Check order: an unknown schema outranks the late corruption checks but
    // not the early ones.
    flt = '0;
    flt.schema   = 1'b1;
    flt.rsv_byte = 1'b1;
    build_record(3, flt, $urandom);
    send_record();
    flt = '0;
    flt.schema   = 1'b1;
    flt.gen_zero = 1'b1;
    build_record(3, flt, $urandom);
    send_record();
    flt = '0;
    flt.schema = 1'b1;
    flt.crc    = 1'b1;
    build_record(3, flt, $urandom);
    send_record();
    drain_and_pause();

    // Smallest valid size limit: a bare header fits, one payload byte does not.
    program_regs(cur_magic, cur_schema, cur_kind, 17'd24);
    build_record(0, '0, $urandom);
    send_record();
    build_record(1, '0, $urandom);
    send_record();
    drain_and_pause();

    // A limit one below the header length is an invalid configuration.
    program_regs(cur_magic, cur_schema, cur_kind, 17'd23);
    build_record(0, '0, $urandom);
    send_record();
    drain_and_pause();

    // ---- Random part ----
    // Each phase gets its own register setting, sender and sink behaviour;
    // the extremes of every register and the invalid settings come round.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      magic_sel  = $urandom;
      schema_sel = 16'($urandom_range(1, 65535));
      kind_sel   = 8'($urandom);
      case (phase)
        0: max_sel = MAX_SIZE_RESET;
        1: begin
          magic_sel  = 32'hffff_ffff;
          schema_sel = 16'hffff;
          kind_sel   = 8'hff;
          max_sel    = 17'd24;
        end
        2: begin
          magic_sel  = '0;
          schema_sel = 16'd1;
          kind_sel   = '0;
          max_sel    = 17'($urandom_range(25, 120));
        end
        3: begin
          schema_sel = '0;
          max_sel    = MAX_SIZE_RESET;
        end
        4: max_sel = 17'd23;
        5: max_sel = 17'($urandom_range(121, 200));
        6: max_sel = 17'd65535;
        default: max_sel = '0;
      endcase
      program_regs(magic_sel, schema_sel, kind_sel, max_sel);
      if (phase % 3 == 2) begin
        sink_mode <= SINK_FREE;
        gap_limit = 0;
      end else begin
        sink_mode <= (phase % 3 == 0) ? SINK_LIGHT : SINK_HEAVY;
        gap_limit = 12;
      end
      for (int r = 0; r < RECORDS_PER_PHASE; r++) send_random_record();
      drain_and_pause();
    end

    // Everything has been answered; allow a few more cycles for anything
    // spurious to show up.
    repeat (8) @(negedge clk);

    $display("Sent %0d records (%0d bytes) under %0d register settings,", records_sent,
             bytes_sent, settings_used);
    $display("with a bursty sender and a stalling sink; %0d verdicts compared.",
             verdict_total);
    if (mismatch_total == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rec_env_pkg.sv
rtl/rec_env_tracker.sv
rtl/rec_env_judge.sv
rtl/record_envelope_checker_unit.sv
test/rec_env_verdict_checker.sv
test/tb.sv
